// File: src/assert_macros.svh
// Assertion macros used by the top level of the frame checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside of reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: src/lpfc_pkg.sv
// Package for the length-prefixed frame checker: widths, codes, register
// defaults and the structs passed between the top level and the frame engine.
// No dependencies.
package lpfc_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned LEN_W    = 16;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 16;

   // Result kinds.
   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // Input modes.
   localparam logic MODE_BYTE = 1'b0;
   localparam logic MODE_TICK = 1'b1;

   // Frame status codes.
   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_ERROR   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_TIMEOUT = 2'd2;

   // Control register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_START_BYTE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_END_BYTE     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_READ_COMMAND = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LENGTH   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_MS   = 3'd4;

   // Register values after reset.
   localparam logic [BYTE_W-1:0] START_BYTE_RST   = 8'd2;
   localparam logic [BYTE_W-1:0] END_BYTE_RST     = 8'd3;
   localparam logic [BYTE_W-1:0] READ_COMMAND_RST = 8'd1;
   localparam logic [LEN_W-1:0]  MAX_LENGTH_RST   = 16'd256;
   localparam logic [LEN_W-1:0]  TIMEOUT_MS_RST   = 16'd2000;

   localparam logic [LEN_W-1:0]  TICKS_MAX = '1;

   typedef struct packed {
      logic [BYTE_W-1:0] start_byte;
      logic [BYTE_W-1:0] end_byte;
      logic [BYTE_W-1:0] read_command;
      logic [LEN_W-1:0]  max_length;
      logic [LEN_W-1:0]  timeout_ms;
   } lpfc_cfg_type;

   typedef struct packed {
      logic                kind;
      logic [BYTE_W-1:0]   data_byte;
      logic [STATUS_W-1:0] status;
      logic [LEN_W-1:0]    frame_length;
   } lpfc_result_type;

   // Combinational outcome of one beat through the frame engine.
   typedef struct packed {
      logic            valid;
      lpfc_result_type result;
   } lpfc_eng_out_type;

endpackage

// File: src/lpfc_if.sv
// Valid/ready channel interfaces of the frame checker: received beats,
// result beats and control register writes. Depends on lpfc_pkg.
interface lpfc_req_if;
   import lpfc_pkg::*;
   logic              valid;
   logic              ready;
   logic              mode;
   logic [BYTE_W-1:0] rx_byte;
   modport source (output valid, output mode, output rx_byte, input ready);
   modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

interface lpfc_rsp_if;
   import lpfc_pkg::*;
   logic                valid;
   logic                ready;
   logic                kind;
   logic [BYTE_W-1:0]   data_byte;
   logic [STATUS_W-1:0] status;
   logic [LEN_W-1:0]    frame_length;
   modport source (output valid, output kind, output data_byte, output status,
                   output frame_length, input ready);
   modport sink   (input valid, input kind, input data_byte, input status,
                   input frame_length, output ready);
endinterface

interface lpfc_csr_if;
   import lpfc_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: src/lpfc_engine.sv
// Frame engine: phase state machine, length and checksum tracking and the
// millisecond timeout, one beat per step. Depends on lpfc_pkg.
module lpfc_engine (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  logic                       mode,
   input  logic [lpfc_pkg::BYTE_W-1:0] rx_byte,
   input  lpfc_pkg::lpfc_cfg_type     cfg,
   output lpfc_pkg::lpfc_eng_out_type eng_out,
   output logic                       idle
);
   import lpfc_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE, PH_CMD, PH_LEN_HI, PH_LEN_LO, PH_DATA, PH_SUM_HI, PH_SUM_LO, PH_END
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [LEN_W-1:0]  length_ff, length_in;
   logic [LEN_W-1:0]  left_ff, left_in;
   logic [LEN_W-1:0]  sum_ff, sum_in;
   logic [BYTE_W-1:0] sum_hi_ff, sum_hi_in;
   logic              cmd_ok_ff, cmd_ok_in;
   logic [LEN_W-1:0]  ticks_ff, ticks_in;

   logic              to_idle;
   logic [LEN_W-1:0]  ticks_inc;
   logic [LEN_W-1:0]  len_full;

   assign idle      = (phase_ff == PH_IDLE);
   assign ticks_inc = (ticks_ff == TICKS_MAX) ? ticks_ff : ticks_ff + LEN_W'(1);
   assign len_full  = {length_ff[LEN_W-1:BYTE_W], rx_byte};

   always_comb begin
      phase_in  = phase_ff;
      length_in = length_ff;
      left_in   = left_ff;
      sum_in    = sum_ff;
      sum_hi_in = sum_hi_ff;
      cmd_ok_in = cmd_ok_ff;
      ticks_in  = ticks_ff;
      to_idle   = 1'b0;
      eng_out   = '0;
      if (mode == MODE_TICK) begin
         if (phase_ff != PH_IDLE) begin
            ticks_in = ticks_inc;
            if (ticks_inc >= cfg.timeout_ms) begin
               eng_out.valid               = 1'b1;
               eng_out.result.kind         = KIND_STATUS;
               eng_out.result.status       = ST_TIMEOUT;
               eng_out.result.frame_length = length_ff;
               to_idle                     = 1'b1;
            end
         end
      end else begin
         unique case (phase_ff)
            PH_IDLE: begin
               if (rx_byte != cfg.start_byte) begin
                  eng_out.valid         = 1'b1;
                  eng_out.result.kind   = KIND_STATUS;
                  eng_out.result.status = ST_ERROR;
               end else begin
                  phase_in = PH_CMD;
               end
               length_in = '0;
               left_in   = '0;
               sum_in    = '0;
               sum_hi_in = '0;
               cmd_ok_in = 1'b0;
               ticks_in  = '0;
            end
            PH_CMD: begin
               cmd_ok_in = (rx_byte == cfg.read_command);
               phase_in  = PH_LEN_HI;
            end
            PH_LEN_HI: begin
               length_in = {rx_byte, BYTE_W'(0)};
               phase_in  = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               length_in = len_full;
               if (len_full > cfg.max_length) begin
                  eng_out.valid               = 1'b1;
                  eng_out.result.kind         = KIND_STATUS;
                  eng_out.result.status       = ST_ERROR;
                  eng_out.result.frame_length = len_full;
                  to_idle                     = 1'b1;
               end else begin
                  left_in  = len_full;
                  phase_in = (len_full == '0) ? PH_SUM_HI : PH_DATA;
               end
            end
            PH_DATA: begin
               sum_in  = sum_ff + LEN_W'(rx_byte);
               left_in = left_ff - LEN_W'(1);
               if (left_ff == LEN_W'(1)) begin
                  phase_in = PH_SUM_HI;
               end
               eng_out.valid               = 1'b1;
               eng_out.result.kind         = KIND_DATA;
               eng_out.result.data_byte    = rx_byte;
               eng_out.result.frame_length = length_ff;
            end
            PH_SUM_HI: begin
               sum_hi_in = rx_byte;
               phase_in  = PH_SUM_LO;
            end
            PH_SUM_LO: begin
               if (sum_ff != {sum_hi_ff, rx_byte}) begin
                  cmd_ok_in = 1'b0;
               end
               phase_in = PH_END;
            end
            PH_END: begin
               eng_out.valid               = 1'b1;
               eng_out.result.kind         = KIND_STATUS;
               eng_out.result.status       = (cmd_ok_ff && (rx_byte == cfg.end_byte)) ?
                                             ST_OK : ST_ERROR;
               eng_out.result.frame_length = length_ff;
               to_idle                     = 1'b1;
            end
         endcase
      end
      if (to_idle) begin
         phase_in  = PH_IDLE;
         length_in = '0;
         left_in   = '0;
         sum_in    = '0;
         sum_hi_in = '0;
         cmd_ok_in = 1'b0;
         ticks_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         length_ff <= '0;
         left_ff   <= '0;
         sum_ff    <= '0;
         sum_hi_ff <= '0;
         cmd_ok_ff <= 1'b0;
         ticks_ff  <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         length_ff <= length_in;
         left_ff   <= left_in;
         sum_ff    <= sum_in;
         sum_hi_ff <= sum_hi_in;
         cmd_ok_ff <= cmd_ok_in;
         ticks_ff  <= ticks_in;
      end
   end

endmodule

// File: src/length_prefixed_frame_checker.sv
// Length-prefixed frame checker, top level. Depends on lpfc_pkg, the
// channel interfaces in lpfc_if.sv, lpfc_engine and assert_macros.svh.
// Path: a beat moves from the input register through the engine into the result register, which drives rsp.
// Throughput: one beat per cycle, set by the single engine pass between the
// input register and the result register; ready drops only while a result waits.
// Reset (synchronous, active high) empties both registers, returns the engine
// to idle and loads the control registers with their default values.
module length_prefixed_frame_checker (
   input  logic         clock,
   input  logic         reset,
   lpfc_req_if.sink     req_if,
   lpfc_rsp_if.source   rsp_if,
   lpfc_csr_if.sink     csr_if
);
   import lpfc_pkg::*;
   `include "assert_macros.svh"

   // Control registers. Writes are taken at any time; the user writes them
   // only while no frame is in flight.
   lpfc_cfg_type cfg_ff;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_byte   <= START_BYTE_RST;
         cfg_ff.end_byte     <= END_BYTE_RST;
         cfg_ff.read_command <= READ_COMMAND_RST;
         cfg_ff.max_length   <= MAX_LENGTH_RST;
         cfg_ff.timeout_ms   <= TIMEOUT_MS_RST;
      end else if (csr_if.valid) begin
         unique case (csr_if.index)
            CSR_START_BYTE:   cfg_ff.start_byte   <= csr_if.data[BYTE_W-1:0];
            CSR_END_BYTE:     cfg_ff.end_byte     <= csr_if.data[BYTE_W-1:0];
            CSR_READ_COMMAND: cfg_ff.read_command <= csr_if.data[BYTE_W-1:0];
            CSR_MAX_LENGTH:   cfg_ff.max_length   <= csr_if.data;
            CSR_TIMEOUT_MS:   cfg_ff.timeout_ms   <= csr_if.data;
            default: ;
         endcase
      end
   end

   // Input register. The pipeline moves whenever the result register is
   // free or is being emptied in this cycle, so a held result beat and a
   // freshly accepted beat can sit side by side.
   logic              in_valid_ff;
   logic              in_mode_ff;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              advance;
   logic              step;

   logic            out_valid_ff;
   lpfc_result_type out_data_ff;

   lpfc_eng_out_type eng_out;
   logic             eng_idle;

   assign advance      = !out_valid_ff || rsp_if.ready;
   assign req_if.ready = advance;
   assign step         = in_valid_ff && advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && req_if.valid) begin
         in_mode_ff <= req_if.mode;
         in_byte_ff <= req_if.rx_byte;
      end
   end

   // The engine commits its state only on the cycle the beat moves on, so a
   // stalled beat is evaluated again unchanged.
   lpfc_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .mode    (in_mode_ff),
      .rx_byte (in_byte_ff),
      .cfg     (cfg_ff),
      .eng_out (eng_out),
      .idle    (eng_idle)
   );

   // Result register. Beats that give no result (ticks below the timeout, header
   // bytes that pass their checks, checksum bytes) simply leave it empty.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff && eng_out.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (step && eng_out.valid) begin
         out_data_ff <= eng_out.result;
      end
   end

   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.kind         = out_data_ff.kind;
   assign rsp_if.data_byte    = out_data_ff.data_byte;
   assign rsp_if.status       = out_data_ff.status;
   assign rsp_if.frame_length = out_data_ff.frame_length;

   // A status beat always closes the frame, so the engine must be idle after.
   `ASSERT_CLK(a_status_closes_frame, clock, reset, (step && eng_out.valid && (eng_out.result.kind == KIND_STATUS)) |=> eng_idle, "engine not idle after a frame status")

   // Payload only flows inside a frame whose length is known and nonzero.
   `ASSERT_CLK(a_payload_has_length, clock, reset, (rsp_if.valid && (rsp_if.kind == KIND_DATA)) |-> (rsp_if.frame_length != '0), "payload beat with zero frame length")

   // A stalled input beat keeps its contents until it moves on.
   `ASSERT_CLK(a_input_held, clock, reset, (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_mode_ff) && $stable(in_byte_ff)), "input register changed while stalled")

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for length_prefixed_frame_checker: drives received and tick
// beats, predicts every result beat and compares them. Depends on lpfc_pkg, lpfc_if.sv
// and the RTL of the frame checker.
module tb;
   import lpfc_pkg::*;

   // A result trails its beat through the input and result registers, so SETTLE_CYCLES
   // spare cycles cover beats still inside the block after the last expected result is out.
   localparam int SETTLE_CYCLES    = 6;
   localparam int WATCHDOG_LIMIT   = 5000;
   localparam int MAX_REPORTED     = 10;
   // The receiver stops taking results for a long stretch once this many have been
   // seen; the sender keeps offering beats meanwhile, so the block fills and stalls.
   localparam int LONG_HOLD_AT     = 150;
   localparam int LONG_HOLD_CYCLES = 300;

   typedef enum logic [2:0] {
      FR_IDLE, FR_CMD, FR_LEN_HI, FR_LEN_LO, FR_DATA, FR_SUM_HI, FR_SUM_LO, FR_END
   } frame_phase_type;

   typedef struct packed {
      logic              mode;
      logic [BYTE_W-1:0] rx_byte;
   } rx_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lpfc_req_if req_ch ();
   lpfc_rsp_if rsp_ch ();
   lpfc_csr_if csr_ch ();

   length_prefixed_frame_checker DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   always #1 clock = ~clock;

   // Beats still to be offered, and the result beats the frame predictor has worked
   // out for beats the block already took, oldest first.
   rx_beat_type     rx_beats_pending[$];
   lpfc_result_type frame_results_due[$];

   // Register values as the block holds them, kept up to date on each write.
   lpfc_cfg_type active_cfg;

   // Predicted receiver state.
   frame_phase_type   fr_phase   = FR_IDLE;
   logic [LEN_W-1:0]  fr_len     = '0;
   logic [LEN_W-1:0]  fr_left    = '0;
   logic [LEN_W-1:0]  fr_sum     = '0;
   logic [BYTE_W-1:0] fr_sum_hi  = '0;
   logic              fr_cmd_ok  = 1'b0;
   logic [LEN_W-1:0]  fr_ticks   = '0;

   int req_idle_pct = 27;
   int rsp_idle_pct = 65;
   int rsp_hold_left = 0;
   int quiet_cycles = 0;

   int mismatches = 0;
   int beats_accepted = 0;
   int results_seen = 0;
   int payload_seen = 0;
   int ok_seen = 0;
   int error_seen = 0;
   int timeout_seen = 0;
   int settings_applied = 1;

   // Directed opening: an idle tick (ignored), a stray byte, a good two-byte frame with
   // a tick inside it, an empty frame closed by a wrong end byte, and a frame whose
   // length of 257 is one above the default maximum.
   rx_beat_type directed_beats[$] = '{
      {MODE_TICK, 8'hC3},
      {MODE_BYTE, 8'hFF},
      {MODE_BYTE, 8'h02}, {MODE_BYTE, 8'h01}, {MODE_BYTE, 8'h00}, {MODE_BYTE, 8'h02},
      {MODE_BYTE, 8'hAA}, {MODE_TICK, 8'h3C}, {MODE_BYTE, 8'h55},
      {MODE_BYTE, 8'h00}, {MODE_BYTE, 8'hFF}, {MODE_BYTE, 8'h03},
      {MODE_BYTE, 8'h02}, {MODE_BYTE, 8'h01}, {MODE_BYTE, 8'h00}, {MODE_BYTE, 8'h00},
      {MODE_BYTE, 8'h00}, {MODE_BYTE, 8'h00}, {MODE_BYTE, 8'h04},
      {MODE_BYTE, 8'h02}, {MODE_BYTE, 8'h01}, {MODE_BYTE, 8'h01}, {MODE_BYTE, 8'h01}
   };

   function automatic rx_beat_type beat_of(logic mode, logic [BYTE_W-1:0] b);
      return {mode, b};
   endfunction

   function automatic void clear_frame_state();
      fr_phase  = FR_IDLE;
      fr_len    = '0;
      fr_left   = '0;
      fr_sum    = '0;
      fr_sum_hi = '0;
      fr_cmd_ok = 1'b0;
      fr_ticks  = '0;
   endfunction

   // Advances the predicted receiver by one accepted beat and queues the result beat
   // that it gives, if any. Every status beat sends the receiver back to idle.
   function automatic void predict_frame_beat(logic mode, logic [BYTE_W-1:0] b);
      lpfc_result_type r;
      logic emit;
      r = '0;
      emit = 1'b0;
      if (mode == MODE_TICK) begin
         // Ticks only count while a frame is open; the counter saturates.
         if (fr_phase != FR_IDLE) begin
            if (fr_ticks != TICKS_MAX) fr_ticks++;
            if (fr_ticks >= active_cfg.timeout_ms) begin
               r.kind = KIND_STATUS;
               r.status = ST_TIMEOUT;
               r.frame_length = fr_len;
               emit = 1'b1;
            end
         end
      end else begin
         case (fr_phase)
            FR_IDLE: begin
               if (b != active_cfg.start_byte) begin
                  r.kind = KIND_STATUS;
                  r.status = ST_ERROR;
                  emit = 1'b1;
               end else begin
                  fr_phase = FR_CMD;
               end
            end
            FR_CMD: begin
               fr_cmd_ok = (b == active_cfg.read_command);
               fr_phase = FR_LEN_HI;
            end
            FR_LEN_HI: begin
               fr_len = {b, 8'h00};
               fr_phase = FR_LEN_LO;
            end
            FR_LEN_LO: begin
               fr_len[7:0] = b;
               if (fr_len > active_cfg.max_length) begin
                  r.kind = KIND_STATUS;
                  r.status = ST_ERROR;
                  r.frame_length = fr_len;
                  emit = 1'b1;
               end else begin
                  fr_left = fr_len;
                  fr_phase = (fr_len == '0) ? FR_SUM_HI : FR_DATA;
               end
            end
            FR_DATA: begin
               fr_sum += b;
               fr_left--;
               if (fr_left == '0) fr_phase = FR_SUM_HI;
               r.kind = KIND_DATA;
               r.data_byte = b;
               r.frame_length = fr_len;
               emit = 1'b1;
            end
            FR_SUM_HI: begin
               fr_sum_hi = b;
               fr_phase = FR_SUM_LO;
            end
            FR_SUM_LO: begin
               // From here on the flag means command and checksum were both good.
               if (fr_sum != {fr_sum_hi, b}) fr_cmd_ok = 1'b0;
               fr_phase = FR_END;
            end
            default: begin
               r.kind = KIND_STATUS;
               r.status = (fr_cmd_ok && b == active_cfg.end_byte) ? ST_OK : ST_ERROR;
               r.frame_length = fr_len;
               emit = 1'b1;
            end
         endcase
      end
      if (emit) begin
         if (r.kind == KIND_STATUS) clear_frame_state();
         frame_results_due.push_back(r);
      end
   endfunction

   // Queues one frame built from the current register values and returns its beat
   // count. Most frames are well formed with random payloads; some carry a wrong
   // command, checksum or end byte, an oversize length, stray ticks, a tick burst
   // around the timeout, or are cut short.
   function automatic int add_frame(int forced_len);
      rx_beat_type fr[$];
      int len;
      int cap;
      int r;
      int cut;
      int burst;
      int pos;
      logic [BYTE_W-1:0] b;
      logic [LEN_W-1:0] sum;
      logic [LEN_W-1:0] sent;
      logic too_long;
      sum = '0;
      r = $urandom_range(0, 99);
      cap = (active_cfg.max_length < 12) ? active_cfg.max_length : 12;
      if (forced_len >= 0)
         len = forced_len;
      else if (r < 8 && active_cfg.max_length != 16'hFFFF)
         len = $urandom_range(0, 1) ? active_cfg.max_length + 1
                                    : $urandom_range(active_cfg.max_length + 1, 65535);
      else if (r < 14 && active_cfg.max_length <= 40)
         len = active_cfg.max_length;
      else
         len = $urandom_range(0, cap);
      too_long = (len > active_cfg.max_length);

      fr.push_back(beat_of(MODE_BYTE, active_cfg.start_byte));
      fr.push_back(beat_of(MODE_BYTE, ($urandom_range(0, 99) < 88) ? active_cfg.read_command
                                                                   : 8'($urandom)));
      fr.push_back(beat_of(MODE_BYTE, len[15:8]));
      fr.push_back(beat_of(MODE_BYTE, len[7:0]));
      // An oversize length ends the frame, so nothing past it is sent.
      if (!too_long) begin
         repeat (len) begin
            b = 8'($urandom);
            sum += b;
            fr.push_back(beat_of(MODE_BYTE, b));
         end
         sent = ($urandom_range(0, 99) < 88) ? sum : 16'($urandom);
         fr.push_back(beat_of(MODE_BYTE, sent[15:8]));
         fr.push_back(beat_of(MODE_BYTE, sent[7:0]));
         fr.push_back(beat_of(MODE_BYTE, ($urandom_range(0, 99) < 88) ? active_cfg.end_byte
                                                                      : 8'($urandom)));
      end

      for (int i = fr.size() - 1; i >= 1; i--)
         if ($urandom_range(0, 99) < 6) fr.insert(i, beat_of(MODE_TICK, 8'($urandom)));

      if (active_cfg.timeout_ms <= 64 && $urandom_range(0, 99) < 12) begin
         burst = $urandom_range(active_cfg.timeout_ms > 2 ? active_cfg.timeout_ms - 2 : 0,
                                active_cfg.timeout_ms + 1);
         pos = $urandom_range(1, fr.size() - 1);
         repeat (burst) fr.insert(pos, beat_of(MODE_TICK, 8'($urandom)));
      end

      if ($urandom_range(0, 99) < 12) begin
         cut = $urandom_range(1, fr.size() - 1);
         fr = fr[0:cut-1];
      end

      foreach (fr[i]) rx_beats_pending.push_back(fr[i]);
      return fr.size();
   endfunction

   // Queues about n beats: mostly frames, the rest loose bytes and ticks. Loose ticks
   // are left out of the count since an idle receiver drops them.
   function automatic void add_random_traffic(int n);
      int added;
      logic m;
      added = 0;
      while (added < n) begin
         if ($urandom_range(0, 99) < 12) begin
            repeat ($urandom_range(1, 3)) begin
               m = 1'($urandom_range(0, 1));
               rx_beats_pending.push_back(beat_of(m, 8'($urandom)));
               if (m == MODE_BYTE) added++;
            end
         end else begin
            added += add_frame(-1);
         end
      end
   endfunction

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= val;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      case (idx)
         CSR_START_BYTE:   active_cfg.start_byte   = val[BYTE_W-1:0];
         CSR_END_BYTE:     active_cfg.end_byte     = val[BYTE_W-1:0];
         CSR_READ_COMMAND: active_cfg.read_command = val[BYTE_W-1:0];
         CSR_MAX_LENGTH:   active_cfg.max_length   = val;
         CSR_TIMEOUT_MS:   active_cfg.timeout_ms   = val;
         default: ;
      endcase
   endtask

   // Writes all five registers, then steps to a falling edge so that beats queued next
   // never meet the driver within the same time step.
   task automatic write_config(lpfc_cfg_type c);
      csr_write(CSR_START_BYTE, CSR_DATA_W'(c.start_byte));
      csr_write(CSR_END_BYTE, CSR_DATA_W'(c.end_byte));
      csr_write(CSR_READ_COMMAND, CSR_DATA_W'(c.read_command));
      csr_write(CSR_MAX_LENGTH, c.max_length);
      csr_write(CSR_TIMEOUT_MS, c.timeout_ms);
      settings_applied++;
      @(negedge clock);
   endtask

   // Returns once every queued beat was taken and every predicted result has come
   // out, plus a few cycles for beats that give no result. Polled on the falling edge,
   // where nothing in the bench or the block is changing.
   task automatic wait_drained();
      do @(negedge clock);
      while (rx_beats_pending.size() != 0 || req_ch.valid || frame_results_due.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic void check_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
         mismatches++;
         if (mismatches <= MAX_REPORTED)
            $display("Mismatch in %s of result beat %0d: expected 0x%0h, got 0x%0h",
                     field, results_seen, want, got);
      end
   endfunction

   // Driver: offers the next pending beat unless this cycle is chosen as a gap. A beat
   // already on the channel stays until the block takes it. The predictor runs on
   // exactly the beats that the block accepted.
   always @(posedge clock) begin
      rx_beat_type nxt;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            beats_accepted++;
            predict_frame_beat(req_ch.mode, req_ch.rx_byte);
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (rx_beats_pending.size() != 0 && $urandom_range(0, 99) >= req_idle_pct) begin
               nxt = rx_beats_pending.pop_front();
               req_ch.valid   <= 1'b1;
               req_ch.mode    <= nxt.mode;
               req_ch.rx_byte <= nxt.rx_byte;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each result beat against the oldest prediction and drives ready,
   // with random stalls and one long hold-off counted here.
   always @(posedge clock) begin
      lpfc_result_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            results_seen++;
            if (rsp_ch.kind == KIND_DATA) begin
               payload_seen++;
            end else begin
               case (rsp_ch.status)
                  ST_OK:      ok_seen++;
                  ST_TIMEOUT: timeout_seen++;
                  default:    error_seen++;
               endcase
            end
            if (frame_results_due.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTED)
                  $display("Unexpected result beat %0d: kind %0d byte 0x%0h status %0d len %0d",
                           results_seen, rsp_ch.kind, rsp_ch.data_byte, rsp_ch.status,
                           rsp_ch.frame_length);
            end else begin
               want = frame_results_due.pop_front();
               check_field("kind", want.kind, rsp_ch.kind);
               check_field("data_byte", want.data_byte, rsp_ch.data_byte);
               check_field("status", want.status, rsp_ch.status);
               check_field("frame_length", want.frame_length, rsp_ch.frame_length);
            end
            if (results_seen == LONG_HOLD_AT) rsp_hold_left = LONG_HOLD_CYCLES;
         end
         if (rsp_hold_left > 0) begin
            rsp_hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
         end
      end
   end

   // Watchdog: a correct run never goes this long without a single accepted beat.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no beat accepted for %0d cycles, %0d results still due",
                  quiet_cycles, frame_results_due.size());
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      lpfc_cfg_type c;
      req_ch.valid   = 1'b0;
      req_ch.mode    = MODE_BYTE;
      req_ch.rx_byte = '0;
      rsp_ch.ready   = 1'b0;
      csr_ch.valid   = 1'b0;
      csr_ch.index   = CSR_START_BYTE;
      csr_ch.data    = '0;
      active_cfg = '{START_BYTE_RST, END_BYTE_RST, READ_COMMAND_RST,
                     MAX_LENGTH_RST, TIMEOUT_MS_RST};
      clear_frame_state();

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed beats run on the register defaults; the sender idles less than the
      // receiver in this first stretch.
      foreach (directed_beats[i]) rx_beats_pending.push_back(directed_beats[i]);
      wait_drained();

      // Widest limits: no timeout can occur, and one payload longer than the default
      // maximum is accepted.
      c = '{8'h00, 8'hFF, 8'h00, 16'hFFFF, 16'hFFFF};
      write_config(c);
      void'(add_frame(260));
      add_random_traffic(250);
      wait_drained();

      // Narrowest limits, with the idling roles swapped: only empty payloads pass and
      // any tick inside a frame times it out.
      req_idle_pct = 65;
      rsp_idle_pct = 27;
      c = '{8'hFF, 8'h00, 8'hFF, 16'h0000, 16'h0001};
      write_config(c);
      add_random_traffic(250);
      wait_drained();

      // Random bytes and small limits so that boundary lengths and tick bursts around
      // the timeout come up often. The sender pauses halfway until all results are in.
      c.start_byte   = 8'($urandom);
      c.end_byte     = 8'($urandom);
      c.read_command = 8'($urandom);
      c.max_length   = 16'($urandom_range(8, 40));
      c.timeout_ms   = 16'($urandom_range(10, 40));
      write_config(c);
      add_random_traffic(200);
      wait_drained();
      add_random_traffic(200);
      wait_drained();

      // Back to back on both sides.
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      c.start_byte   = 8'($urandom);
      c.end_byte     = 8'($urandom);
      c.read_command = 8'($urandom);
      c.max_length   = 16'($urandom_range(1, 16));
      c.timeout_ms   = 16'($urandom_range(3, 30));
      write_config(c);
      add_random_traffic(250);
      wait_drained();

      $display("Covered %0d input beats under %0d register settings; %0d result beats checked",
               beats_accepted, settings_applied, results_seen);
      $display("Frames closed: %0d ok, %0d error, %0d timeout; %0d payload beats passed on",
               ok_seen, error_seen, timeout_seen, payload_seen);
      if (mismatches == 0 && frame_results_due.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("%0d mismatches, %0d results never arrived",
                  mismatches, frame_results_due.size());
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
